@@ hdl/bakery_ticket_arbiter_defines.svh @@
// Assertion macros shared by the bakery ticket arbiter RTL.
`ifndef BAKERY_TICKET_ARBITER_DEFINES_SVH
`define BAKERY_TICKET_ARBITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bta_pkg.sv @@
// Package of types and constants for the bakery ticket arbiter.
`default_nettype none

package bta_pkg;

    localparam int NUM_REQ_DEF     = 16;
    localparam int TICKET_BITS_DEF = 16;

    localparam int STATUS_W     = 2;
    localparam int REQ_W        = 4;
    localparam int TICKET_OUT_W = 16;
    localparam int ID_OUT_W     = 4;

    localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

@@ hdl/bta_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module bta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/bakery_ticket_arbiter.sv @@
// An accepted event starts a scan of the ticket table; the finishing cycle can accept the next one.
// The pace is set by the ticket table's single read port: one entry is read per cycle, then the
// finishing cycle writes back and issues the result into the output register.
// Reset (synchronous, active low) empties the ticket table at once through per-entry valid flags,
// so no clearing pass is needed; the output register is emptied and the block is ready at once.
// A result held in the output register by a stall holds the finishing cycle, and the next event.
`default_nettype none

module bakery_ticket_arbiter #(
    parameter int NUM_REQ     = bta_pkg::NUM_REQ_DEF,
    parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Event channel.
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_action,
    input  wire logic [bta_pkg::REQ_W-1:0]          i_requester,
    // Result channel.
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic      [bta_pkg::STATUS_W-1:0]       o_status,
    output logic      [bta_pkg::TICKET_OUT_W-1:0]   o_ticket,
    output logic                                    o_grant_valid,
    output logic      [bta_pkg::ID_OUT_W-1:0]       o_grant_id
);

    import bta_pkg::*;

    `include "bakery_ticket_arbiter_defines.svh"

    localparam int IDW = $clog2(NUM_REQ);
    localparam int CW  = $clog2(NUM_REQ + 1);
    localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};

    // Control state.
    t_state                 r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [NUM_REQ-1:0]     r_vld, n_vld;

    // The event being served.
    logic                   r_act, n_act;
    logic [REQ_W-1:0]       r_who, n_who;

    // Scan accumulators: the largest ticket, the requester's own entry, and the
    // smallest nonzero ticket among all other requesters.
    logic [TICKET_BITS-1:0] r_max, n_max;
    logic [TICKET_BITS-1:0] r_own, n_own;
    logic                   r_found, n_found;
    logic [TICKET_BITS-1:0] r_best, n_best;
    logic [IDW-1:0]         r_bid, n_bid;

    // Read-side bookkeeping for the table RAM.
    logic                   r_rd_vld, n_rd_vld;
    logic                   r_fwd_hit, n_fwd_hit;
    logic [TICKET_BITS-1:0] r_fwd_dat, n_fwd_dat;

    // Output register.
    logic                   r_ovld, n_ovld;
    logic [STATUS_W-1:0]    r_ostat, n_ostat;
    logic [TICKET_OUT_W-1:0] r_otick, n_otick;
    logic                   r_ogv, n_ogv;
    logic [ID_OUT_W-1:0]    r_ogid, n_ogid;

    // RAM ports.
    logic                   ram_we, ram_re;
    logic [IDW-1:0]         ram_waddr, ram_raddr;
    logic [TICKET_BITS-1:0] ram_wdata, ram_q;

    // Helpers.
    logic                   in_acc;
    logic                   fin_go;
    logic                   who_ok;
    logic [IDW-1:0]         who_idx;
    logic [CW-1:0]          cnt_m1;
    logic [IDW-1:0]         scan_idx;
    logic [TICKET_BITS-1:0] scan_dat;

    // Finishing cycle results.
    logic [STATUS_W-1:0]    f_status;
    logic [TICKET_BITS-1:0] f_ticket;
    logic [TICKET_BITS-1:0] f_own_new;
    logic                   f_gv;
    logic [IDW-1:0]         f_gid;
    logic [31:0]            f_ticket_ext;
    logic [31:0]            f_gid_ext;

    bta_ram #(
        .WIDTH (TICKET_BITS),
        .DEPTH (NUM_REQ)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // The finishing cycle may only complete when the output register can take the result.
    assign fin_go  = (r_state == ST_FIN) && (!r_ovld || !i_stall);
    assign o_stall = !((r_state == ST_IDLE) || fin_go);
    assign in_acc  = i_valid && !o_stall;

    assign who_ok  = (32'(r_who) < 32'(NUM_REQ));
    assign who_idx = IDW'(r_who);

    // Entry index whose data is arriving from the RAM this cycle.
    assign cnt_m1   = r_cnt - CW'(1);
    assign scan_idx = cnt_m1[IDW-1:0];

    // Entries never written since reset read as zero; a read that collided with a
    // write of the same entry takes the written value.
    assign scan_dat = r_fwd_hit ? r_fwd_dat : (r_rd_vld ? ram_q : '0);

    // Reads: entry 0 on acceptance, then one entry per cycle while scanning.
    assign ram_re    = in_acc || ((r_state == ST_SCAN) && (r_cnt < CW'(NUM_REQ)));
    assign ram_raddr = (r_state == ST_SCAN) ? r_cnt[IDW-1:0] : '0;

    // Outcome of the event, worked out from the scan totals in the finishing cycle.
    always_comb begin
        f_status  = STAT_DONE;
        f_ticket  = '0;
        f_own_new = '0;
        ram_we    = 1'b0;
        ram_wdata = '0;
        if (!who_ok) begin
            f_status = STAT_IGNORED;
        end else if (r_act == ACT_ACQUIRE) begin
            if (r_own != '0) begin
                f_status  = STAT_IGNORED;
                f_ticket  = r_own;
                f_own_new = r_own;
            end else if (r_max == TICKET_MAX) begin
                f_status = STAT_OVERFLOW;
            end else begin
                f_ticket  = r_max + TICKET_BITS'(1);
                f_own_new = f_ticket;
                ram_we    = fin_go;
                ram_wdata = f_ticket;
            end
        end else begin
            if (r_own == '0) begin
                f_status = STAT_IGNORED;
            end else begin
                ram_we    = fin_go;
                ram_wdata = '0;
            end
        end

        // Fold the requester's new entry into the holder found among the others.
        f_gv  = r_found;
        f_gid = r_bid;
        if ((f_own_new != '0) &&
            (!r_found || (f_own_new < r_best) ||
             ((f_own_new == r_best) && (who_idx < r_bid)))) begin
            f_gv  = 1'b1;
            f_gid = who_idx;
        end
        if (!f_gv) begin
            f_gid = '0;
        end
        f_ticket_ext = 32'(f_ticket);
        f_gid_ext    = 32'(f_gid);
    end

    assign ram_waddr = who_idx;

    // Next-state logic for the sequencer, the scan and the output register.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_vld     = r_vld;
        n_act     = r_act;
        n_who     = r_who;
        n_max     = r_max;
        n_own     = r_own;
        n_found   = r_found;
        n_best    = r_best;
        n_bid     = r_bid;
        n_rd_vld  = ram_re ? r_vld[ram_raddr] : r_rd_vld;
        n_fwd_hit = ram_re && ram_we && (ram_raddr == ram_waddr);
        n_fwd_dat = ram_wdata;
        n_ovld    = r_ovld && i_stall;
        n_ostat   = r_ostat;
        n_otick   = r_otick;
        n_ogv     = r_ogv;
        n_ogid    = r_ogid;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_dat > r_max) begin
                    n_max = scan_dat;
                end
                if (who_ok && (scan_idx == who_idx)) begin
                    n_own = scan_dat;
                end else if ((scan_dat != '0) && (!r_found || (scan_dat < r_best))) begin
                    n_found = 1'b1;
                    n_best  = scan_dat;
                    n_bid   = scan_idx;
                end
                if (r_cnt == CW'(NUM_REQ)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    if (ram_we) begin
                        n_vld[ram_waddr] = 1'b1;
                    end
                    n_ovld  = 1'b1;
                    n_ostat = f_status;
                    n_otick = f_ticket_ext[TICKET_OUT_W-1:0];
                    n_ogv   = f_gv;
                    n_ogid  = f_gid_ext[ID_OUT_W-1:0];
                    n_state = in_acc ? ST_SCAN : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A newly accepted event starts a fresh scan.
        if (in_acc) begin
            n_act   = i_action;
            n_who   = i_requester;
            n_cnt   = CW'(1);
            n_max   = '0;
            n_own   = '0;
            n_found = 1'b0;
            n_best  = '0;
            n_bid   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vld     <= '0;
            r_ovld    <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vld     <= n_vld;
            r_ovld    <= n_ovld;
            r_fwd_hit <= n_fwd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_act     <= n_act;
        r_who     <= n_who;
        r_max     <= n_max;
        r_own     <= n_own;
        r_found   <= n_found;
        r_best    <= n_best;
        r_bid     <= n_bid;
        r_rd_vld  <= n_rd_vld;
        r_fwd_dat <= n_fwd_dat;
        r_ostat   <= n_ostat;
        r_otick   <= n_otick;
        r_ogv     <= n_ogv;
        r_ogid    <= n_ogid;
    end

    assign o_valid       = r_ovld;
    assign o_status      = r_ostat;
    assign o_ticket      = r_otick;
    assign o_grant_valid = r_ogv;
    assign o_grant_id    = r_ogid;

    // The scan counter stays within the table while scanning.
    `BTA_ASSERT_NOW(a_scan_range, i_clk, i_rst_n, r_state == ST_SCAN,
        (r_cnt >= CW'(1)) && (r_cnt <= CW'(NUM_REQ)), "scan counter out of range")

    // A completed finishing cycle always leaves a result beat in the output register.
    `BTA_ASSERT_NEXT(a_fin_result, i_clk, i_rst_n, fin_go, r_ovld,
        "finishing cycle did not produce a result")

    // The table is written only in the finishing cycle.
    `BTA_ASSERT_NOW(a_write_fin, i_clk, i_rst_n, ram_we, r_state == ST_FIN,
        "table written outside the finishing cycle")

    // A refused acquire never reports a ticket.
    `BTA_ASSERT_NOW(a_ovf_ticket, i_clk, i_rst_n, r_ovld && (r_ostat == STAT_OVERFLOW),
        r_otick == '0, "overflow result carries a ticket")

endmodule

`default_nettype wire

@@ bench/bakery_ticket_arbiter_tb.sv @@
// Self-checking testbench for the bakery ticket arbiter: directed and random events.
`timescale 1ns / 1ps

module bakery_ticket_arbiter_tb;

    import bta_pkg::*;

    // A watchdog limit far above the slowest legal gap between two handshakes
    // (sender gap, one event's scan of the table, the pipeline latency and a receiver stall).
    localparam int WATCHDOG_LIMIT = 1000;
    // Quiet cycles after the last result, enough to see any stray beat from the pipeline.
    localparam int DRAIN_CYCLES   = NUM_REQ_DEF + 24;
    localparam int RANDOM_EVENTS  = 500;
    localparam logic [TICKET_OUT_W-1:0] TICKET_TOP = '1;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [TICKET_OUT_W-1:0] ticket;
        logic                    grant_valid;
        logic [ID_OUT_W-1:0]     grant_id;
    } t_ticket_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_action;
    logic [REQ_W-1:0]        i_requester;
    logic                    o_valid;
    logic                    i_stall;
    logic [STATUS_W-1:0]     o_status;
    logic [TICKET_OUT_W-1:0] o_ticket;
    logic                    o_grant_valid;
    logic [ID_OUT_W-1:0]     o_grant_id;

    // The testbench's own copy of the ticket table, updated as each event beat is accepted.
    logic [TICKET_OUT_W-1:0] ticket_tab [NUM_REQ_DEF];
    // Results still owed by the block, oldest first.
    t_ticket_result          owed_results [$];
    // When clear, neither side inserts gaps or stalls.
    bit                      bursty;
    int                      error_count;
    int                      quiet_cycles;
    int                      stall_left;

    bakery_ticket_arbiter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_requester   (i_requester),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_ticket      (o_ticket),
        .o_grant_valid (o_grant_valid),
        .o_grant_id    (o_grant_id)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The largest ticket currently held, or zero when the table is empty.
    function automatic logic [TICKET_OUT_W-1:0] highest_ticket();
        logic [TICKET_OUT_W-1:0] top;
        top = '0;
        for (int k = 0; k < NUM_REQ_DEF; k++) begin
            if (ticket_tab[k] > top) begin
                top = ticket_tab[k];
            end
        end
        return top;
    endfunction

    // Applies one accepted event to the table and queues the result it must produce.
    task automatic apply_event(input logic act, input logic [REQ_W-1:0] who);
        t_ticket_result          want;
        logic [TICKET_OUT_W-1:0] top;
        want = '0;
        want.status = STAT_DONE;
        if (act == ACT_ACQUIRE) begin
            if (ticket_tab[who] != '0) begin
                // A requester already waiting keeps its ticket; the acquire is ignored.
                want.status = STAT_IGNORED;
                want.ticket = ticket_tab[who];
            end else begin
                top = highest_ticket();
                if (top == TICKET_TOP) begin
                    // No ticket above the largest one exists, so the acquire is refused.
                    want.status = STAT_OVERFLOW;
                end else begin
                    ticket_tab[who] = top + 1'b1;
                    want.ticket = top + 1'b1;
                end
            end
        end else if (ticket_tab[who] == '0) begin
            // Releasing without holding a ticket changes nothing.
            want.status = STAT_IGNORED;
        end else begin
            ticket_tab[who] = '0;
        end
        // The holder is the smallest nonzero ticket; scanning upwards with a strict compare
        // lets the lower id win a tie.
        for (int k = 0; k < NUM_REQ_DEF; k++) begin
            if (ticket_tab[k] != '0 &&
                (!want.grant_valid || ticket_tab[k] < ticket_tab[want.grant_id])) begin
                want.grant_valid = 1'b1;
                want.grant_id    = k[ID_OUT_W-1:0];
            end
        end
        owed_results.push_back(want);
    endtask

    // Sends one event beat and returns at the edge that accepts it. Valid is left high, so a
    // following call with no gap presents its beat without a dip; a call with a gap lowers it.
    task automatic send_event(input logic act, input logic [REQ_W-1:0] who);
        int gap;
        gap = bursty ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action    <= act;
        i_requester <= who;
        i_valid     <= 1'b1;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        apply_event(act, who);
    endtask

    // Releasing with nothing held must be ignored at both ends of the id range.
    task automatic test_idle_release();
        send_event(ACT_RELEASE, 4'd0);
        send_event(ACT_RELEASE, 4'd15);
    endtask

    // Tickets are handed out in arrival order and the first arrival holds the grant.
    task automatic test_acquire_order();
        send_event(ACT_ACQUIRE, 4'd5);
        send_event(ACT_ACQUIRE, 4'd3);
        send_event(ACT_ACQUIRE, 4'd15);
        send_event(ACT_ACQUIRE, 4'd0);
        send_event(ACT_ACQUIRE, 4'd10);
    endtask

    // A second acquire by a waiting requester reports the ticket it already holds.
    task automatic test_reacquire_ignored();
        send_event(ACT_ACQUIRE, 4'd3);
        send_event(ACT_ACQUIRE, 4'd15);
        send_event(ACT_RELEASE, 4'd7);
    endtask

    // Releasing the holder passes the grant on; a late arrival takes a ticket above all others.
    task automatic test_release_handover();
        send_event(ACT_RELEASE, 4'd5);
        send_event(ACT_ACQUIRE, 4'd5);
        send_event(ACT_RELEASE, 4'd15);
        send_event(ACT_RELEASE, 4'd3);
        send_event(ACT_RELEASE, 4'd10);
        send_event(ACT_RELEASE, 4'd0);
        send_event(ACT_RELEASE, 4'd5);
        // With the table empty again the grant vanishes and numbering restarts at one.
        send_event(ACT_ACQUIRE, 4'd15);
        send_event(ACT_RELEASE, 4'd15);
    endtask

    // Random traffic in blocks: each block picks whether gaps are allowed, how crowded the
    // id space is and how strongly acquires outweigh releases.
    task automatic test_random_events();
        int   pool_top;
        int   acquire_pct;
        logic act;
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n % 40 == 0) begin
                bursty      = ($urandom_range(0, 3) != 0);
                pool_top    = ($urandom_range(0, 2) == 0) ? 3 : 15;
                acquire_pct = $urandom_range(35, 75);
            end
            act = ($urandom_range(0, 99) < acquire_pct) ? ACT_ACQUIRE : ACT_RELEASE;
            send_event(act, REQ_W'($urandom_range(0, pool_top)));
        end
        bursty = 1'b1;
    endtask

    // Releasing every holder empties the table, after which numbering restarts at one and
    // the grant follows the order of arrival again.
    task automatic test_table_drain();
        for (int k = 0; k < NUM_REQ_DEF; k++) begin
            if (ticket_tab[k] != '0) begin
                send_event(ACT_RELEASE, REQ_W'(k));
            end
        end
        send_event(ACT_ACQUIRE, 4'd7);
        send_event(ACT_ACQUIRE, 4'd0);
        send_event(ACT_RELEASE, 4'd7);
        send_event(ACT_RELEASE, 4'd0);
    endtask

    // Result side: checks each accepted result beat against the oldest owed one, and after each
    // one draws how many cycles the next result is held off before being taken.
    always @(posedge i_clk) begin : result_monitor
        t_ticket_result got;
        t_ticket_result want;
        int             hold;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_ticket, o_grant_valid, o_grant_id};
            if (owed_results.size() == 0) begin
                error_count++;
                $display("%0t: expected no result beat, got status %0d ticket %0d grant %0b/%0d",
                         $time, got.status, got.ticket, got.grant_valid, got.grant_id);
            end else begin
                want = owed_results.pop_front();
                if (got != want) begin
                    error_count++;
                    $display("%0t: mismatch: expected status %0d ticket %0d grant %0b/%0d,",
                             $time, want.status, want.ticket, want.grant_valid,
                             want.grant_id);
                    $display("%0t:           got status %0d ticket %0d grant %0b/%0d",
                             $time, got.status, got.ticket, got.grant_valid, got.grant_id);
                end
            end
            hold = bursty ? $urandom_range(0, 4) : 0;
            stall_left <= hold;
            i_stall    <= (hold != 0);
        end else if (i_rst_n && o_valid && stall_left != 0) begin
            // The hold-off only counts down while a result beat is actually presented.
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left != 1);
        end
    end

    // Watchdog: ends the run if no beat crosses either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= ACT_ACQUIRE;
        i_requester <= '0;
        i_stall     <= 1'b0;
        error_count = 0;
        bursty      = 1'b1;
        for (int k = 0; k < NUM_REQ_DEF; k++) begin
            ticket_tab[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_release();
        test_acquire_order();
        test_reacquire_ignored();
        test_release_handover();
        test_random_events();
        test_table_drain();

        // All stimulus is in: stop offering beats and let the owed results come home.
        i_valid <= 1'b0;
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
